[rtl/aes_cbc_pkg.sv]
// Shared AES tables and round helper functions for the CBC cipher block.
package aes_cbc_pkg;

  localparam int unsigned NumRounds = 10;

  typedef logic [127:0] aes_blk_t;

  typedef enum logic [2:0] {
    REG_KEY_UPPER    = 3'd0,
    REG_KEY_LOWER    = 3'd1,
    REG_IV_UPPER     = 3'd2,
    REG_IV_LOWER     = 3'd3,
    REG_DECRYPT_MODE = 3'd4
  } cfg_reg_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // Byte i of a block sits at bits [127-8i -: 8].
  function automatic logic [7:0] get_byte(aes_blk_t b, int i);
    return b[127 - 8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic aes_blk_t sub_bytes(aes_blk_t b, logic inv);
    aes_blk_t t;
    for (int i = 0; i < 16; i++) begin
      t[127 - 8*i -: 8] = inv ? INV_SBOX[get_byte(b, i)] : SBOX[get_byte(b, i)];
    end
    return t;
  endfunction

  function automatic aes_blk_t shift_rows(aes_blk_t b, logic inv);
    aes_blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          t[127 - 8*(r + 4*((c + r) % 4)) -: 8] = get_byte(b, r + 4*c);
        end else begin
          t[127 - 8*(r + 4*c) -: 8] = get_byte(b, r + 4*((c + r) % 4));
        end
      end
    end
    return t;
  endfunction

  function automatic aes_blk_t mix_columns(aes_blk_t b, logic inv);
    aes_blk_t t;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m1 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]   = get_byte(b, 4*c + k);
        x2[k]  = xtime(a[k]);
        x4[k]  = xtime(x2[k]);
        x8[k]  = xtime(x4[k]);
        m1[k]  = a[k];
        m2[k]  = x2[k];
        m3[k]  = x2[k] ^ a[k];
        m9[k]  = x8[k] ^ a[k];
        m11[k] = x8[k] ^ x2[k] ^ a[k];
        m13[k] = x8[k] ^ x4[k] ^ a[k];
        m14[k] = x8[k] ^ x4[k] ^ x2[k];
      end
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          t[127 - 8*(4*c + r) -: 8] = m14[r] ^ m11[(r + 1) % 4] ^
                                     m13[(r + 2) % 4] ^ m9[(r + 3) % 4];
        end else begin
          t[127 - 8*(4*c + r) -: 8] = m2[r] ^ m3[(r + 1) % 4] ^
                                     m1[(r + 2) % 4] ^ m1[(r + 3) % 4];
        end
      end
    end
    return t;
  endfunction

  // Next round key from the current one, four words chained.
  function automatic aes_blk_t next_round_key(aes_blk_t k, logic [7:0] rc);
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    logic [31:0] tw;
    w3 = k[31:0];
    tw = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = k[127:96] ^ tw;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    return {w0, w1, w2, w2 ^ w3};
  endfunction

endpackage

[rtl/aes128_cbc_block_cipher.sv]
// AES-128 CBC block cipher with iterated round unit and round key memory.
// One 128-bit block per beat, split into two 64-bit halves with byte 0 in the
// most significant bits of the upper half. Each block passes once through
// the round unit (one initial key addition, then ten rounds) on the single
// shared round datapath. The final round waits while the output register
// holds a stalled result; the next block is taken in the cycle after the
// result is loaded into the output register, and not before. The eleven
// round keys live in a synchronous memory; they are expanded one round key
// per cycle after reset and after every write of a key register,
// during which no input beat is taken. Configuration writes are always taken
// (cfg_ready is tied high) and must only be made while the block is idle.
// A set restart_chain flag reloads the chain value from the IV registers.
module aes128_cbc_block_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_block_upper,
  input  logic [63:0] in_block_lower,
  input  logic        in_restart_chain,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_upper,
  output logic [63:0] out_result_lower
);
  import aes_cbc_pkg::*;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t     state_r;
  logic [3:0] cnt_r;
  logic [3:0] exp_cnt_r;
  logic       exp_busy_r;
  aes_blk_t   kexp_r;
  aes_blk_t   st_r;
  aes_blk_t   chain_r;
  aes_blk_t   blk_r;
  aes_blk_t   rk_q;
  aes_blk_t   out_r;
  logic       out_valid_r;
  logic [63:0] key_upper_r;
  logic [63:0] key_lower_r;
  logic [63:0] iv_upper_r;
  logic [63:0] iv_lower_r;
  logic        decrypt_r;

  // Round key memory, one 128-bit round key per entry.
  aes_blk_t   rk_mem [NumRounds + 1];

  logic       cfg_we;
  logic       in_acc;
  logic       out_free;
  logic [3:0] cnt_nxt;
  logic [3:0] rd_addr;
  aes_blk_t   chain_in;
  aes_blk_t   blk_in;
  aes_blk_t   round_out;
  aes_blk_t   fwd_t;
  aes_blk_t   inv_t;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign in_stall  = (state_r != ST_IDLE) | exp_busy_r;
  assign in_acc    = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign out_valid = out_valid_r;
  assign out_result_upper = out_r[127:64];
  assign out_result_lower = out_r[63:0];

  assign blk_in   = {in_block_upper, in_block_lower};
  assign chain_in = in_restart_chain ? {iv_upper_r, iv_lower_r} : chain_r;

  // Round number that the next cycle works on; the key read is issued now.
  always_comb begin
    if (state_r == ST_RUN && cnt_r != 4'(NumRounds)) begin
      cnt_nxt = cnt_r + 4'd1;
    end else if (state_r == ST_RUN) begin
      cnt_nxt = cnt_r;
    end else begin
      cnt_nxt = 4'd0;
    end
    rd_addr = decrypt_r ? (4'(NumRounds) - cnt_nxt) : cnt_nxt;
  end

  // One round of either direction; the final round skips the column mix.
  always_comb begin
    fwd_t = shift_rows(sub_bytes(st_r, 1'b0), 1'b0);
    if (cnt_r != 4'(NumRounds)) begin
      fwd_t = mix_columns(fwd_t, 1'b0);
    end
    inv_t = sub_bytes(shift_rows(st_r, 1'b1), 1'b1) ^ rk_q;
    if (cnt_r != 4'(NumRounds)) begin
      inv_t = mix_columns(inv_t, 1'b1);
    end
    round_out = decrypt_r ? inv_t : (fwd_t ^ rk_q);
  end

  always_ff @(posedge clk) begin
    if (exp_busy_r) begin
      rk_mem[exp_cnt_r] <= kexp_r;
    end
    rk_q <= rk_mem[rd_addr];
  end

  // Configuration registers and key expansion sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_upper_r <= '0;
      key_lower_r <= '0;
      iv_upper_r  <= '0;
      iv_lower_r  <= '0;
      decrypt_r   <= 1'b0;
      kexp_r      <= '0;
      exp_cnt_r   <= '0;
      exp_busy_r  <= 1'b1;
    end else begin
      if (exp_busy_r) begin
        exp_cnt_r <= exp_cnt_r + 4'd1;
        if (exp_cnt_r == 4'(NumRounds)) begin
          exp_busy_r <= 1'b0;
        end else begin
          kexp_r <= next_round_key(kexp_r, RCON[exp_cnt_r]);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_UPPER: begin
            key_upper_r <= cfg_data;
            kexp_r      <= {cfg_data, key_lower_r};
            exp_cnt_r   <= '0;
            exp_busy_r  <= 1'b1;
          end
          REG_KEY_LOWER: begin
            key_lower_r <= cfg_data;
            kexp_r      <= {key_upper_r, cfg_data};
            exp_cnt_r   <= '0;
            exp_busy_r  <= 1'b1;
          end
          REG_IV_UPPER:     iv_upper_r <= cfg_data;
          REG_IV_LOWER:     iv_lower_r <= cfg_data;
          REG_DECRYPT_MODE: decrypt_r  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Block sequencer: load, initial key addition, ten rounds, then hand the result to the output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      chain_r     <= '0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            st_r    <= decrypt_r ? blk_in : (blk_in ^ chain_in);
            chain_r <= chain_in;
            blk_r   <= blk_in;
            cnt_r   <= '0;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (cnt_r == 4'd0) begin
            st_r  <= st_r ^ rk_q;
            cnt_r <= cnt_nxt;
          end else if (cnt_r != 4'(NumRounds)) begin
            st_r  <= round_out;
            cnt_r <= cnt_nxt;
          end else if (out_free) begin
            out_r       <= decrypt_r ? (round_out ^ chain_r) : round_out;
            chain_r     <= decrypt_r ? blk_r : round_out;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the AES-128 CBC block cipher with randomized flow control.
`timescale 1ns / 100ps

module tb_top;
  import aes_cbc_pkg::*;

  // Hex text layout of the standard 128-bit key schedule test key, used as one directed key.
  localparam logic [63:0] KeyStdUpper = 64'h2b7e151628aed2a6;
  localparam logic [63:0] KeyStdLower = 64'habf7158809cf4f3c;
  localparam int unsigned RandomBlocks = 980;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] in_block_upper;
  logic [63:0] in_block_lower;
  logic        in_restart_chain;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_result_upper;
  logic [63:0] out_result_lower;

  aes128_cbc_block_cipher i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_block_upper   (in_block_upper),
    .in_block_lower   (in_block_lower),
    .in_restart_chain (in_restart_chain),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_upper (out_result_upper),
    .out_result_lower (out_result_lower)
  );

  typedef struct packed {
    logic [63:0] upper;
    logic [63:0] lower;
    logic        restart;
  } cbc_beat_t;

  // Model copy of the block's registers and chaining state.
  logic [127:0] mdl_key;
  logic [127:0] mdl_iv;
  logic         mdl_decrypt;
  logic [127:0] mdl_chain;
  logic [127:0] mdl_round_keys [11];

  cbc_beat_t    pending_blocks[$];
  logic [127:0] expected_text[$];
  int unsigned  mismatch_count;
  int unsigned  gap_left;
  int unsigned  stall_left;
  bit           hold_sender;
  bit           sim_done;

  always #2 clk = ~clk;

  function automatic logic [7:0] inv_sbox_byte(logic [7:0] v);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (SBOX[i] == v) begin
        r = i[7:0];
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        p = p ^ a;
      end
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // Written word by word from the standard schedule; round key r is words 4r..4r+3.
  task automatic expand_model_key();
    logic [31:0] w [44];
    logic [31:0] t;
    w[0] = mdl_key[127:96];
    w[1] = mdl_key[95:64];
    w[2] = mdl_key[63:32];
    w[3] = mdl_key[31:0];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]} ^
            {RCON[i/4 - 1], 24'h0};
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) begin
      mdl_round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    end
  endtask

  // Full AES-128 cipher or inverse cipher on a block; byte k sits at bits [127-8k -: 8].
  function automatic logic [127:0] aes_transform(logic [127:0] blk, bit inverse,
                                                 logic [127:0] rk [11]);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] fm [4];
    int rnd;
    int step;
    if (inverse) begin
      fm = '{8'd14, 8'd11, 8'd13, 8'd9};
    end else begin
      fm = '{8'd2, 8'd3, 8'd1, 8'd1};
    end
    for (int k = 0; k < 16; k++) begin
      s[k] = blk[127-8*k -: 8] ^ rk[inverse ? 10 : 0][127-8*k -: 8];
    end
    for (step = 1; step <= 10; step++) begin
      rnd = inverse ? 10 - step : step;
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          if (inverse) begin
            t[r + 4*((c + r) % 4)] = inv_sbox_byte(s[r + 4*c]);
          end else begin
            t[r + 4*c] = SBOX[s[r + 4*((c + r) % 4)]];
          end
        end
      end
      // Forward rounds mix before the key; inverse rounds add the key before unmixing.
      if (inverse) begin
        for (int k = 0; k < 16; k++) begin
          t[k] = t[k] ^ rk[rnd][127-8*k -: 8];
        end
      end
      if (step != 10) begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) begin
            s[4*c + r] = 8'h00;
            for (int k = 0; k < 4; k++) begin
              s[4*c + r] = s[4*c + r] ^ gf_mul(t[4*c + k], fm[(k - r + 4) % 4]);
            end
          end
        end
      end else begin
        s = t;
      end
      if (!inverse) begin
        for (int k = 0; k < 16; k++) begin
          s[k] = s[k] ^ rk[rnd][127-8*k -: 8];
        end
      end
    end
    for (int k = 0; k < 16; k++) begin
      blk[127-8*k -: 8] = s[k];
    end
    return blk;
  endfunction

  // Computes the CBC result of one block and advances the model chain.
  task automatic predict_cbc_block(cbc_beat_t b);
    logic [127:0] blk;
    logic [127:0] res;
    blk = {b.upper, b.lower};
    if (b.restart) begin
      mdl_chain = mdl_iv;
    end
    if (!mdl_decrypt) begin
      res = aes_transform(blk ^ mdl_chain, 1'b0, mdl_round_keys);
      mdl_chain = res;
    end else begin
      res = aes_transform(blk, 1'b1, mdl_round_keys) ^ mdl_chain;
      mdl_chain = blk;
    end
    expected_text = {expected_text, res};
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 45) begin
      return 0;
    end else if (p < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  // Sender: the beat at the queue head stays on the bus until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_cbc_block(pending_blocks.pop_front());
      end
      if (in_valid && in_stall) begin
        // Hold the stalled beat unchanged.
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_blocks.size() != 0 && !hold_sender) begin
        // A beat taken at this edge has already left the queue, so the head is next.
        cbc_beat_t nb;
        nb = pending_blocks[0];
        in_valid         <= 1'b1;
        in_block_upper   <= nb.upper;
        in_block_lower   <= nb.lower;
        in_restart_chain <= nb.restart;
        gap_left         <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks every result beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_text.size() == 0) begin
          report_mismatch("unexpected beat", out_result_upper, 64'h0);
        end else begin
          logic [127:0] want;
          want = expected_text.pop_front();
          if (out_result_upper !== want[127:64]) begin
            report_mismatch("result_upper", out_result_upper, want[127:64]);
          end
          if (out_result_lower !== want[63:0]) begin
            report_mismatch("result_lower", out_result_lower, want[63:0]);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else begin
        out_stall  <= 1'b0;
        stall_left <= pick_gap();
      end
    end
  end

  // Configuration writes are only made while the block is idle.
  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_KEY_UPPER:    begin mdl_key[127:64] = val; expand_model_key(); end
      REG_KEY_LOWER:    begin mdl_key[63:0] = val; expand_model_key(); end
      REG_IV_UPPER:     mdl_iv[127:64] = val;
      REG_IV_LOWER:     mdl_iv[63:0] = val;
      REG_DECRYPT_MODE: mdl_decrypt = val[0];
      default: ;
    endcase
  endtask

  task automatic setup_cipher(logic [127:0] key, logic [127:0] iv, bit decrypt);
    write_reg(REG_KEY_UPPER, key[127:64]);
    write_reg(REG_KEY_LOWER, key[63:0]);
    write_reg(REG_IV_UPPER, iv[127:64]);
    write_reg(REG_IV_LOWER, iv[63:0]);
    // Upper data bits are junk; only bit 0 selects the direction.
    write_reg(REG_DECRYPT_MODE, {$urandom, 31'($urandom), decrypt});
    cfg_valid <= 1'b0;
  endtask

  // Waits for the pipeline to drain so registers may change safely.
  task automatic drain_pipeline();
    while (pending_blocks.size() != 0 || in_valid || expected_text.size() != 0) begin
      @(posedge clk);
    end
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_block(logic [63:0] u, logic [63:0] l, bit rs);
    cbc_beat_t b;
    b.upper   = u;
    b.lower   = l;
    b.restart = rs;
    pending_blocks = {pending_blocks, b};
  endtask

  initial begin
    logic [127:0] key;
    logic [127:0] iv;
    int unsigned  sent;
    int unsigned  phase_len;
    clk              = 1'b0;
    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = REG_KEY_UPPER;
    cfg_data         = '0;
    in_valid         = 1'b0;
    in_block_upper   = '0;
    in_block_lower   = '0;
    in_restart_chain = 1'b0;
    out_stall        = 1'b0;
    hold_sender      = 1'b0;
    mismatch_count   = 0;
    sim_done         = 1'b0;
    mdl_key          = '0;
    mdl_iv           = '0;
    mdl_decrypt      = 1'b0;
    mdl_chain        = '0;
    expand_model_key();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // The key schedule is rebuilt after reset; the block holds off input itself.
    repeat (2) @(posedge clk);

    // Directed: reset all-zero key, standard key both ways, all-ones key; field extremes.
    queue_block(64'h0, 64'h0, 1'b0);
    queue_block('1, '1, 1'b0);
    queue_block('1, 64'h0, 1'b1);
    queue_block(64'h0, '1, 1'b0);
    drain_pipeline();
    setup_cipher({KeyStdUpper, KeyStdLower}, 128'h000102030405060708090a0b0c0d0e0f, 1'b0);
    queue_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 1'b1);
    queue_block(64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 1'b0);
    queue_block(64'h8000000000000000, 64'h0000000000000001, 1'b0);
    drain_pipeline();
    setup_cipher({KeyStdUpper, KeyStdLower}, 128'h000102030405060708090a0b0c0d0e0f, 1'b1);
    queue_block(64'h7649abac8119b246, 64'hcee98e9b12e9197d, 1'b1);
    queue_block(64'h5086cb9b507219ee, 64'h95db113a917678b2, 1'b0);
    queue_block('1, '1, 1'b1);
    queue_block(64'h0, 64'h0, 1'b0);
    drain_pipeline();
    setup_cipher('1, '1, 1'b1);
    queue_block(64'h0, 64'h0, 1'b1);
    queue_block('1, '1, 1'b0);
    queue_block(rand64(), rand64(), 1'b1);
    drain_pipeline();
    setup_cipher('1, '1, 1'b0);
    queue_block(64'h0, 64'h0, 1'b1);
    queue_block('1, '1, 1'b1);
    queue_block(rand64(), rand64(), 1'b0);
    drain_pipeline();

    // Random phases: fresh key and IV, long chains with occasional restarts.
    sent = 0;
    while (sent < RandomBlocks) begin
      key = {rand64(), rand64()};
      iv  = {rand64(), rand64()};
      if ($urandom_range(0, 7) == 0) key = '0;
      if ($urandom_range(0, 7) == 0) iv = '1;
      setup_cipher(key, iv, 1'($urandom_range(0, 1)));
      phase_len = $urandom_range(20, 120);
      for (int i = 0; i < phase_len; i++) begin
        queue_block(rand64(), rand64(), $urandom_range(0, 9) == 0);
      end
      sent += phase_len;
      // Once, make the sender wait until every expected result has come back.
      if (sent > 300 && sent <= 300 + phase_len) begin
        while (pending_blocks.size() > phase_len / 2) @(posedge clk);
        hold_sender = 1'b1;
        while (in_valid || expected_text.size() != 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain_pipeline();
    end

    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    sim_done = 1'b1;
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    if (!sim_done) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

endmodule
